>>> rtl/nfba_pkg.sv
// Shared types and codes for the next-fit block allocator.
// No dependencies.
package nfba_pkg;

  localparam int unsigned BYTES_W  = 16;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned TOTAL_W  = 11;
  localparam int unsigned TOTAL_MAX = 2047;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_FIT   = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_t;

  typedef struct packed {
    op_t                  operation;
    logic [BYTES_W-1:0]   request_bytes;
    logic [INDEX_W-1:0]   release_index;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [INDEX_W-1:0]   grant_index;
    logic [TOTAL_W-1:0]   allocated_units;
    logic [TOTAL_W-1:0]   high_water_units;
  } rsp_t;

endpackage

>>> rtl/nfba_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module nfba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/next_fit_block_allocator_core.sv
// Next-fit block allocator: list walker over one header RAM.
// Depends on nfba_pkg and nfba_ram.
//
// Takes one beat at a time. A free reads its header and, if in use, writes it back as free;
// a free with an out-of-range index goes straight to the result. An allocate walks the
// list, each entry visited or merged being one read through the single header RAM port,
// and writes one more header when the block is split. A stalled result holds the block
// until it is taken. After reset the head and tail headers are written before a beat.
module next_fit_block_allocator_core
  import nfba_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 1024,
  parameter int unsigned UNIT_BYTES  = 32,
  parameter int unsigned SLACK_UNITS = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int unsigned DEPTH = NUM_ENTRIES + 2;
  localparam int unsigned TAIL  = NUM_ENTRIES + 1;
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned UW    = BYTES_W + 1;
  localparam int unsigned CW    = ((IW > UW) ? IW : UW) + 2;
  localparam int unsigned RK    = UW + $clog2(UNIT_BYTES);
  localparam int unsigned RM    = ((2 ** RK) + UNIT_BYTES - 1) / UNIT_BYTES;
  localparam int unsigned PW    = UW + RK + 1;
  localparam int unsigned LIMIT = 4 * DEPTH;
  localparam int unsigned SW    = $clog2(LIMIT + 1);

  typedef struct packed {
    logic [IW-1:0] len;
    logic          free;
    logic [IW-1:0] link;
  } entry_t;

  typedef enum logic [3:0] {
    S_INIT_HEAD, S_INIT_TAIL, S_IDLE, S_DIV, S_LOAD, S_RD, S_EV,
    S_FIN, S_SPLIT, S_FRD, S_FEV, S_RES
  } state_t;

  state_t             state;
  logic [UW-1:0]      bytes_sum;
  logic [UW-1:0]      units;
  logic [IW-1:0]      rover;
  logic [IW-1:0]      cur;
  logic [IW-1:0]      cur_len;
  logic               cur_free;
  logic [IW-1:0]      cur_link;
  logic [IW-1:0]      split_idx;
  logic [SW-1:0]      steps;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] high_water;
  status_t            res_status;
  logic [INDEX_W-1:0] res_grant;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  logic [IW-1:0]      ram_raddr;
  logic [2*IW:0]      ram_rdata;
  entry_t             nxt;

  logic [PW-1:0]      prod;
  logic               cur_fits;
  logic               do_merge;
  logic [IW-1:0]      merged_len;
  logic [SW-1:0]      steps_inc;
  logic               no_fit;
  logic [CW-1:0]      split_w;
  logic               whole;
  logic [CW-1:0]      add_amt;
  logic [CW-1:0]      add_sum;
  logic [TOTAL_W-1:0] total_add;
  logic [CW-1:0]      cur_p1;
  logic [CW-1:0]      rel_m1;
  logic               rel_ok;

  nfba_ram #(.WIDTH(2 * IW + 1), .DEPTH(DEPTH)) u_hdr (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign nxt       = entry_t'(ram_rdata);
  assign req_stall = (state != S_IDLE);

  always_comb begin
    prod       = PW'(bytes_sum) * PW'(RM);
    cur_fits   = cur_free && (CW'(cur_len) > CW'(units));
    do_merge   = !cur_fits && cur_free && nxt.free;
    merged_len = cur_len + nxt.len + IW'(1);
    steps_inc  = steps + SW'(1);
    no_fit     = !cur_free || (CW'(cur_len) < CW'(units));
    split_w    = CW'(cur) + CW'(units) + CW'(1);
    whole      = (CW'(cur_len) <= CW'(units) + CW'(SLACK_UNITS)) || (split_w > CW'(TAIL));
    add_amt    = whole ? CW'(cur_len) : CW'(units);
    add_sum    = CW'(total) + add_amt;
    total_add  = (add_sum > CW'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX) : add_sum[TOTAL_W-1:0];
    cur_p1     = CW'(cur) + CW'(1);
    rel_m1     = CW'(req.release_index) - CW'(1);
    rel_ok     = (req.release_index != '0) && (rel_m1 <= CW'(NUM_ENTRIES));

    ram_raddr = cur_link;
    case (state)
      S_DIV:   ram_raddr = rover;
      S_FRD:   ram_raddr = cur;
      default: ram_raddr = cur_link;
    endcase

    ram_we    = 1'b0;
    ram_waddr = cur;
    ram_wdata = '{len: cur_len, free: 1'b0, link: cur_link};
    case (state)
      S_INIT_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '{len: IW'(NUM_ENTRIES), free: 1'b1, link: IW'(TAIL)};
      end
      S_INIT_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(TAIL);
        ram_wdata = '{len: '0, free: 1'b0, link: '0};
      end
      S_EV: begin
        ram_we    = do_merge;
        ram_wdata = '{len: merged_len, free: 1'b1, link: nxt.link};
      end
      S_FIN: begin
        ram_we = !no_fit;
        if (!whole) begin
          ram_waddr = split_w[IW-1:0];
          ram_wdata = '{len: cur_len - IW'(units) - IW'(1), free: 1'b1, link: cur_link};
        end
      end
      S_SPLIT: begin
        ram_we    = 1'b1;
        ram_wdata = '{len: IW'(units), free: 1'b0, link: split_idx};
      end
      S_FEV: begin
        ram_we    = !nxt.free;
        ram_wdata = '{len: nxt.len, free: 1'b1, link: nxt.link};
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT_HEAD;
      rover      <= '0;
      total      <= '0;
      high_water <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_RES) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_INIT_HEAD: state <= S_INIT_TAIL;
        S_INIT_TAIL: state <= S_IDLE;
        S_IDLE: begin
          if (req_valid) begin
            bytes_sum <= UW'(req.request_bytes) + UW'(UNIT_BYTES - 1);
            cur       <= rel_m1[IW-1:0];
            res_grant <= '0;
            if (req.operation == OP_ALLOC) begin
              state <= S_DIV;
            end else if (rel_ok) begin
              state <= S_FRD;
            end else begin
              res_status <= STATUS_BAD_FREE;
              state      <= S_RES;
            end
          end
        end
        S_DIV: begin
          units <= UW'(prod >> RK);
          state <= S_LOAD;
        end
        S_LOAD: begin
          cur      <= rover;
          cur_len  <= nxt.len;
          cur_free <= nxt.free;
          cur_link <= nxt.link;
          steps    <= '0;
          state    <= S_RD;
        end
        S_RD: state <= S_EV;
        S_EV: begin
          steps <= steps_inc;
          if (cur_fits) begin
            state <= S_FIN;
          end else if (do_merge) begin
            if (cur_link == rover) begin
              rover <= nxt.link;
            end
            cur_len  <= merged_len;
            cur_link <= nxt.link;
            state    <= (steps_inc == SW'(LIMIT)) ? S_FIN : S_RD;
          end else begin
            cur      <= cur_link;
            cur_len  <= nxt.len;
            cur_free <= nxt.free;
            cur_link <= nxt.link;
            state    <= (cur_link == rover || steps_inc == SW'(LIMIT)) ? S_FIN : S_RD;
          end
        end
        S_FIN: begin
          if (no_fit) begin
            res_status <= STATUS_NO_FIT;
            state      <= S_RES;
          end else begin
            res_status <= STATUS_OK;
            res_grant  <= cur_p1[INDEX_W-1:0];
            total      <= total_add;
            if (high_water < total_add) begin
              high_water <= total_add;
            end
            if (whole) begin
              rover <= cur_link;
              state <= S_RES;
            end else begin
              rover     <= split_w[IW-1:0];
              split_idx <= split_w[IW-1:0];
              state     <= S_SPLIT;
            end
          end
        end
        S_SPLIT: state <= S_RES;
        S_FRD:   state <= S_FEV;
        S_FEV: begin
          if (nxt.free) begin
            res_status <= STATUS_BAD_FREE;
          end else begin
            res_status <= STATUS_OK;
            total <= (CW'(total) >= CW'(nxt.len)) ? TOTAL_W'(CW'(total) - CW'(nxt.len)) : '0;
            rover <= cur;
          end
          state <= S_RES;
        end
        S_RES: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp       <= '{status: res_status, grant_index: res_grant,
                           allocated_units: total, high_water_units: high_water};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hw_ge_total: assert property (@(posedge clk) disable iff (rst)
    high_water >= total) else $error("high water below allocated total");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state != S_IDLE) else $error("header write while idle");
  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_EV |-> steps < SW'(LIMIT)) else $error("walk past step limit");
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STATUS_OK |-> rsp.grant_index == '0)
    else $error("grant on failed beat");
`endif

endmodule

>>> dv/next_fit_block_allocator_core_tb.sv
// Self-checking testbench for next_fit_block_allocator_core: directed and random
// allocate/free beats, checked against an in-bench next-fit list predictor.
// Depends on nfba_pkg and the allocator RTL.
`timescale 1ns / 100ps

module next_fit_block_allocator_core_tb;
  import nfba_pkg::*;

  localparam int unsigned NUM_ENTRIES = 1024;
  localparam int unsigned UNIT_BYTES  = 32;
  localparam int unsigned SLACK_UNITS = 2;
  localparam int unsigned ENTRY_CNT   = NUM_ENTRIES + 2;
  localparam int unsigned TAIL_HDR    = NUM_ENTRIES + 1;
  localparam int unsigned WALK_MAX    = 4 * ENTRY_CNT;
  localparam int unsigned IDLE_LIMIT  = 200000;

  logic clk, rst;
  logic req_valid, req_stall, rsp_valid, rsp_stall;
  req_t req;
  rsp_t rsp;

  next_fit_block_allocator_core #(
    .NUM_ENTRIES(NUM_ENTRIES), .UNIT_BYTES(UNIT_BYTES), .SLACK_UNITS(SLACK_UNITS)
  ) u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // shadow of the header list
  int unsigned hdr_len[ENTRY_CNT];
  bit          hdr_free[ENTRY_CNT];
  bit          hdr_written[ENTRY_CNT];
  int unsigned hdr_link[ENTRY_CNT];
  int unsigned rover_hdr, alloc_total, peak_total;
  int unsigned live_blocks[$];
  rsp_t        pending_rsp[$];
  int          err_cnt;
  int unsigned idle_cycles;
  bit          gaps_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned next_of(int unsigned e);
    return (e < ENTRY_CNT) ? hdr_link[e] : 0;
  endfunction

  function automatic void grow_total(int unsigned u);
    alloc_total = (alloc_total + u > TOTAL_MAX) ? TOTAL_MAX : alloc_total + u;
    if (peak_total < alloc_total) peak_total = alloc_total;
  endfunction

  function automatic void list_reset();
    for (int i = 0; i < ENTRY_CNT; i++) begin
      hdr_len[i] = 0; hdr_free[i] = 0; hdr_link[i] = 0; hdr_written[i] = 0;
    end
    hdr_len[0] = NUM_ENTRIES; hdr_free[0] = 1; hdr_link[0] = TAIL_HDR;
    hdr_written[0] = 1; hdr_written[TAIL_HDR] = 1;
    rover_hdr = 0; alloc_total = 0; peak_total = 0;
    live_blocks.delete();
  endfunction

  function automatic rsp_t predict_alloc_free(req_t r);
    rsp_t e;
    int unsigned units, cur, nxt, steps, blen, split, h;
    bit done;
    e = '0;
    e.status = STATUS_OK;
    if (r.operation == OP_ALLOC) begin
      units = (int'(r.request_bytes) + UNIT_BYTES - 1) / UNIT_BYTES;
      cur = rover_hdr; steps = 0; done = 0;
      while (!done && steps < WALK_MAX) begin
        nxt = next_of(cur);
        steps++;
        if (hdr_free[cur] && hdr_len[cur] > units) done = 1;
        else if (hdr_free[cur] && hdr_free[nxt]) begin
          if (nxt == rover_hdr) rover_hdr = next_of(nxt);
          hdr_len[cur] = hdr_len[cur] + hdr_len[nxt] + 1;
          hdr_link[cur] = next_of(nxt);
        end else begin
          cur = nxt;
          done = (cur == rover_hdr);
        end
      end
      if (!hdr_free[cur] || hdr_len[cur] < units) e.status = STATUS_NO_FIT;
      else begin
        blen = hdr_len[cur];
        split = cur + units + 1;
        if (blen <= units + SLACK_UNITS || split > TAIL_HDR) begin
          hdr_free[cur] = 0;
          rover_hdr = hdr_link[cur];
          grow_total(blen);
        end else begin
          hdr_len[split] = blen - (units + 1);
          hdr_free[split] = 1;
          hdr_written[split] = 1;
          hdr_link[split] = hdr_link[cur];
          hdr_link[cur] = split;
          hdr_len[cur] = units;
          hdr_free[cur] = 0;
          rover_hdr = split;
          grow_total(units);
        end
        e.grant_index = INDEX_W'(cur + 1);
        live_blocks.push_back(cur + 1);
      end
    end else begin
      h = int'(r.release_index) - 1;
      if (r.release_index == 0 || h > NUM_ENTRIES || hdr_free[h]) e.status = STATUS_BAD_FREE;
      else begin
        hdr_free[h] = 1;
        alloc_total = (alloc_total >= hdr_len[h]) ? alloc_total - hdr_len[h] : 0;
        rover_hdr = h;
        foreach (live_blocks[i])
          if (live_blocks[i] == r.release_index) begin
            live_blocks.delete(i);
            break;
          end
      end
    end
    e.allocated_units = TOTAL_W'(alloc_total);
    e.high_water_units = TOTAL_W'(peak_total);
    return e;
  endfunction

  task automatic send_beat(op_t op, int unsigned bytes, int unsigned idx);
    req_t r;
    r.operation = op;
    r.request_bytes = BYTES_W'(bytes);
    r.release_index = INDEX_W'(idx);
    @(negedge clk);
    req_valid = 1'b1;
    req = r;
    do @(posedge clk); while (req_stall);
    pending_rsp.push_back(predict_alloc_free(r));
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      req_valid = 1'b0;
      req.request_bytes = BYTES_W'($urandom);
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
  endtask

  task automatic send_alloc(int unsigned bytes);
    send_beat(OP_ALLOC, bytes, $urandom_range(0, 2047));
  endtask

  task automatic send_free(int unsigned idx);
    send_beat(OP_FREE, $urandom_range(0, 65535), idx);
  endtask

  function automatic int unsigned pick_written();
    int unsigned cand[$];
    for (int i = 0; i <= NUM_ENTRIES; i++)
      if (hdr_written[i]) cand.push_back(i + 1);
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  function automatic int unsigned rand_bytes();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(0, 256);
    if (p < 95) return $urandom_range(0, 4096);
    return $urandom_range(0, 32768);
  endfunction

  task automatic test_directed();
    send_alloc(32768);
    send_free(1);
    send_free(1);
    send_alloc(0);
    send_alloc(1);
    send_alloc(32);
    send_alloc(33);
    send_alloc(96);
    send_free(0);
    send_free(1026);
    send_free(2047);
    send_free(4);
    send_free(4);
    send_alloc(32768);
    send_alloc(65535 & 16'h7fff);
    send_free(2);
    send_alloc(16);
    send_alloc(31744);
    send_alloc(32768);
    send_free(1);
    send_alloc(1);
  endtask

  task automatic test_random_mix(int n);
    int unsigned p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 55 || live_blocks.size() == 0) send_alloc(rand_bytes());
      else if (p < 90) send_free(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
      else if (p < 96) send_free(pick_written());
      else send_free($urandom_range(0, 1) ? 0 : $urandom_range(1026, 2047));
    end
  endtask

  task automatic test_fill_drain(int rounds);
    int k;
    for (int r = 0; r < rounds; r++) begin
      k = 0;
      while (k < 40 && !(pending_rsp.size() > 0 && pending_rsp[$].status == STATUS_NO_FIT)) begin
        send_alloc($urandom_range(0, 2048));
        k++;
      end
      while (live_blocks.size() > 0)
        send_free(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result %p", $time, rsp);
        err_cnt++;
      end else begin
        rsp_t e;
        e = pending_rsp.pop_front();
        if (rsp.status != e.status || rsp.grant_index != e.grant_index ||
            rsp.allocated_units != e.allocated_units ||
            rsp.high_water_units != e.high_water_units) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, rsp);
          err_cnt++;
        end
      end
    end
  end

  // receiver stall: alternating runs of never / sometimes / mostly stalled
  int unsigned stall_run, stall_mode;
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_run = $urandom_range(5, 80);
      stall_mode = $urandom_range(0, 2);
    end
    stall_run--;
    case (stall_mode)
      0: rsp_stall = 1'b0;
      1: rsp_stall = ($urandom_range(0, 3) == 0);
      default: rsp_stall = ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    err_cnt = 0;
    idle_cycles = 0;
    stall_run = 0;
    gaps_on = 1'b0;
    list_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    gaps_on = 1'b1;
    test_random_mix(340);
    test_fill_drain(4);
    gaps_on = 1'b0;
    test_random_mix(60);
    @(negedge clk);
    req_valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> next_fit_block_allocator_core.f
rtl/nfba_pkg.sv
rtl/nfba_ram.sv
rtl/next_fit_block_allocator_core.sv
dv/next_fit_block_allocator_core_tb.sv
